/* rtl/rrs_pkg.sv */
// Shared types and constants for the rectangle rational scaler.
package rrs_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int IN_W           = 32;
    localparam int SCALE_W        = 32;
    localparam int MAG_W          = IN_W + 1;
    localparam int PROD_W         = MAG_W + SCALE_W;
    localparam int QW             = 34;
    localparam int REM_W          = SCALE_W;
    localparam int RES_W          = QW + 2;
    localparam int LANE_ST        = QW + 3;
    localparam int NST            = LANE_ST + 1;
    localparam int DATA_W         = 128;
    localparam int SIZE_W         = 31;
    localparam int N_LANES        = 4;

    typedef enum logic {
        REG_NUM = 1'b0,
        REG_DEN = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [RES_W-1:0] res;
        logic                    ovf;
    } lane_out_t;

endpackage

/* rtl/rrs_lane.sv */
// One scaling lane: |v|*N, pipelined restoring divide by D, floor or ceil rounding.
module rrs_lane (
    input  logic                          aclk,
    input  logic [rrs_pkg::LANE_ST-1:0]   en,
    input  logic                          ceil_mode,
    input  logic signed [rrs_pkg::MAG_W-1:0] v,
    input  logic [rrs_pkg::SCALE_W-1:0]   num,
    input  logic [rrs_pkg::SCALE_W-1:0]   den,
    output rrs_pkg::lane_out_t            lane_out
);
    import rrs_pkg::*;

    logic              neg_reg   [0:LANE_ST-2];
    logic              ovf_reg   [1:QW];
    logic [MAG_W-1:0]  mag_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QW-1:0]     lo_reg    [0:QW-1];
    logic [REM_W-1:0]  rem_reg   [0:QW-1];
    logic [QW-1:0]     q_reg     [0:QW-1];
    logic [REM_W-1:0]  rem_in    [0:QW-1];
    logic [QW-1:0]     lo_in     [0:QW-1];
    logic [QW-1:0]     q_in      [0:QW-1];
    logic              ovf_in;
    logic              rnz;
    logic              inc;
    logic [QW:0]       fin_mag;
    lane_out_t         out_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            neg_reg[0] <= v[MAG_W-1];
            mag_reg    <= v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
        end
        if (en[1]) begin
            neg_reg[1] <= neg_reg[0];
            prod_reg   <= PROD_W'(mag_reg) * PROD_W'(num);
        end
    end

    assign ovf_in    = {1'b0, prod_reg[PROD_W-1:QW]} >= den;
    assign rem_in[0] = REM_W'(prod_reg[PROD_W-1:QW]);
    assign lo_in[0]  = prod_reg[QW-1:0];
    assign q_in[0]   = '0;

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_div
            logic [REM_W:0] t;
            logic           ge;
            logic           ovf_prev;
            if (j > 0) begin : g_link
                assign rem_in[j] = rem_reg[j-1];
                assign lo_in[j]  = lo_reg[j-1];
                assign q_in[j]   = q_reg[j-1];
                assign ovf_prev  = ovf_reg[j];
            end else begin : g_head
                assign ovf_prev  = ovf_in;
            end
            assign t  = {rem_in[j], lo_in[j][QW-1-j]};
            assign ge = t >= {1'b0, den};
            always_ff @(posedge aclk) begin
                if (en[2+j]) begin
                    rem_reg[j]   <= ge ? REM_W'(t - {1'b0, den}) : t[REM_W-1:0];
                    lo_reg[j]    <= lo_in[j];
                    q_reg[j]     <= {q_in[j][QW-2:0], ge};
                    neg_reg[2+j] <= neg_reg[1+j];
                    ovf_reg[j+1] <= ovf_prev;
                end
            end
        end
    endgenerate

    assign rnz     = rem_reg[QW-1] != '0;
    assign inc     = rnz & (neg_reg[LANE_ST-2] ^ ceil_mode);
    assign fin_mag = {1'b0, q_reg[QW-1]} + (QW+1)'(inc);

    always_ff @(posedge aclk) begin
        if (en[LANE_ST-1]) begin
            out_reg.res <= neg_reg[LANE_ST-2] ? -$signed({1'b0, fin_mag})
                                              :  $signed({1'b0, fin_mag});
            out_reg.ovf <= ovf_reg[QW];
        end
    end

    assign lane_out = out_reg;

endmodule

/* rtl/rrs_merge.sv */
// Combines the four lane edges into width/height, range checks and the result register.
module rrs_merge #(
    parameter int COORD_BITS = rrs_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        bad,
    input  rrs_pkg::lane_out_t          left,
    input  rrs_pkg::lane_out_t          top,
    input  rrs_pkg::lane_out_t          right,
    input  rrs_pkg::lane_out_t          bottom,
    output logic [rrs_pkg::DATA_W-1:0]  result
);
    import rrs_pkg::*;

    localparam logic signed [RES_W:0] CMAX = (RES_W+1)'((64'sd1 <<< (COORD_BITS-1)) - 1);
    localparam logic signed [RES_W:0] CMIN = -CMAX - 1;

    logic signed [RES_W:0] l_e, t_e, r_e, b_e, wd, ht;
    logic                  ok;
    logic [DATA_W-1:0]     result_reg;

    assign l_e = (RES_W+1)'(left.res);
    assign t_e = (RES_W+1)'(top.res);
    assign r_e = (RES_W+1)'(right.res);
    assign b_e = (RES_W+1)'(bottom.res);
    assign wd  = r_e - l_e;
    assign ht  = b_e - t_e;

    assign ok = !bad && !left.ovf && !top.ovf && !right.ovf && !bottom.ovf
             && l_e >= CMIN && l_e <= CMAX && t_e >= CMIN && t_e <= CMAX
             && wd >= 0 && wd <= CMAX && ht >= 0 && ht <= CMAX;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ok) begin
                result_reg <= {1'b0, ht[SIZE_W-1:0], wd[SIZE_W-1:0],
                               t_e[IN_W-1:0], l_e[IN_W-1:0], 1'b1};
            end else begin
                result_reg <= '0;
            end
        end
    end

    assign result = result_reg;

endmodule

/* rtl/rect_rational_scaler.sv */
// Top level: rectangle logical-to-physical scaler with four parallel lanes.
//
//  channel | dir | fields (low bit first)
//  s_      | in  | rect_x[31:0] rect_y[63:32] rect_w[95:64] rect_h[127:96]
//  m_      | out | ok[0] phys_x[32:1] phys_y[64:33] phys_w[95:65] phys_h[126:96]
//  cfg_    | in  | index 0 scale_numerator, 1 scale_denominator
//
// One request per cycle while m_tready lets the pipeline advance; each request passes the
// sign, multiply, 34-step divider pipeline, rounding and merge stages in that order.
// Reset clears the stage valid bits and sets both scale terms to 1.
// Each stage advances when its successor is empty or advancing, so bubbles close
// up under an output stall and s_tready falls only when every stage is full.
module rect_rational_scaler #(
    parameter int COORD_BITS = rrs_pkg::COORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rrs_pkg::DATA_W-1:0]  s_tdata,   // rect_x, rect_y, rect_w, rect_h
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rrs_pkg::DATA_W-1:0]  m_tdata,   // ok, phys_x, phys_y, phys_w, phys_h, pad
    input  logic                        cfg_we,
    input  rrs_pkg::reg_idx_t           cfg_addr,
    input  logic [rrs_pkg::SCALE_W-1:0] cfg_wdata
);
    import rrs_pkg::*;

    logic [SCALE_W-1:0]      num_reg, den_reg;
    logic [NST-1:0]          vld_reg;
    logic [NST:0]            rdy;
    logic [NST-1:0]          en;
    logic                    bad_reg [0:LANE_ST-1];
    logic signed [IN_W-1:0]  x, y, w, h;
    logic signed [MAG_W-1:0] v [0:N_LANES-1];
    lane_out_t               lo [0:N_LANES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= SCALE_W'(1);
            den_reg <= SCALE_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_NUM: num_reg <= cfg_wdata;
                REG_DEN: den_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign rdy[NST] = m_tready;
    genvar i;
    generate
        for (i = 0; i < NST; i++) begin : g_ctl
            assign rdy[i] = !vld_reg[i] || rdy[i+1];
            assign en[i]  = rdy[i];
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (rdy[i]) begin
                    vld_reg[i] <= (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
        for (i = 0; i < LANE_ST; i++) begin : g_bad
            always_ff @(posedge aclk) begin
                if (en[i]) begin
                    bad_reg[i] <= (i == 0) ? (w[IN_W-1] || h[IN_W-1] ||
                                              num_reg == '0 || den_reg == '0)
                                           : bad_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    endgenerate

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NST-1];

    assign x = s_tdata[IN_W-1:0];
    assign y = s_tdata[2*IN_W-1:IN_W];
    assign w = s_tdata[3*IN_W-1:2*IN_W];
    assign h = s_tdata[4*IN_W-1:3*IN_W];

    assign v[0] = MAG_W'(x);
    assign v[1] = MAG_W'(y);
    assign v[2] = MAG_W'(x) + MAG_W'(w);
    assign v[3] = MAG_W'(y) + MAG_W'(h);

    generate
        for (i = 0; i < N_LANES; i++) begin : g_lane
            rrs_lane u_lane (
                .aclk      (aclk),
                .en        (en[LANE_ST-1:0]),
                .ceil_mode (i >= 2),
                .v         (v[i]),
                .num       (num_reg),
                .den       (den_reg),
                .lane_out  (lo[i])
            );
        end
    endgenerate

    rrs_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .aclk   (aclk),
        .en     (en[NST-1]),
        .bad    (bad_reg[LANE_ST-1]),
        .left   (lo[0]),
        .top    (lo[1]),
        .right  (lo[2]),
        .bottom (lo[3]),
        .result (m_tdata)
    );

endmodule

/* rtl/rrs_checker.sv */
// Port-level checks for the rectangle scaler, bound to the top level.
module rrs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rrs_pkg::DATA_W-1:0] m_tdata
);
    import rrs_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] || m_tdata[DATA_W-1:1] == '0)
        else $error("failed result has nonzero fields");

    a_full_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while pipeline has room");

endmodule

bind rect_rational_scaler rrs_checker u_rrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
